// ===== rtl/vrle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrle_pkg
// shared widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package vrle_pkg;

	localparam int DATA_W  = 8;
	localparam int ADDR_W  = 11;
	localparam int LEN_W   = 8;
	localparam int TOTAL_W = 14;
	localparam int COUNT_W = 15;
	localparam int M_TDATA_W = 32;

	localparam logic [DATA_W-1:0]  ESCAPE_BYTE = 8'h91;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 14'd2000;

	localparam int DEF_BYTES_PER_ROW = 20;
	localparam int DEF_ROWS          = 100;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start_run;
		logic seg_last;
	} dp_status_t;

endpackage

// ===== rtl/vrle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrle_ctrl
// controller: input acceptance, segment stepping and output valid
// ----------------------------------------------------------------------------
module vrle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  vrle_pkg::dp_status_t sts,
	output vrle_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cmd.load = in_valid && (state_q == ST_IDLE);
	assign cmd.step = (state_q == ST_RUN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load && sts.start_run) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.step && sts.seg_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/vrle_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrle_dp
// datapath: parse state, screen position, produced count, output register
// ----------------------------------------------------------------------------
module vrle_dp #(
	parameter int BYTES_PER_ROW = vrle_pkg::DEF_BYTES_PER_ROW,
	parameter int ROWS          = vrle_pkg::DEF_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vrle_pkg::ctrl_cmd_t           cmd,
	output vrle_pkg::dp_status_t          sts,
	input  logic [vrle_pkg::DATA_W-1:0]   in_byte,
	input  logic                          in_restart,
	input  logic                          cfg_we,
	input  logic [vrle_pkg::TOTAL_W-1:0]  cfg_total,
	output logic [vrle_pkg::DATA_W-1:0]   fill_value,
	output logic [vrle_pkg::ADDR_W-1:0]   start_address,
	output logic [vrle_pkg::LEN_W-1:0]    seg_length,
	output logic                          last_segment,
	output logic                          all_done
);

	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
	localparam int SPAN_W = vrle_pkg::LEN_W + 1;
	localparam int PROD_RAW_W = ROW_W + COL_W + 2;
	localparam int PROD_W = (PROD_RAW_W > vrle_pkg::ADDR_W) ? PROD_RAW_W : vrle_pkg::ADDR_W;
	localparam logic [SPAN_W-1:0] ROWS_EXT = SPAN_W'(ROWS);
	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(BYTES_PER_ROW - 1);

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_VALUE  = 2'd1,
		PH_COUNT  = 2'd2
	} phase_t;

	phase_t                        phase_q;
	logic [vrle_pkg::DATA_W-1:0]   run_value_q;
	logic [ROW_W-1:0]              row_q;
	logic [COL_W-1:0]              col_q;
	logic [vrle_pkg::COUNT_W-1:0]  count_q;
	logic [vrle_pkg::TOTAL_W-1:0]  total_q;
	logic [vrle_pkg::DATA_W-1:0]   seg_value_q;
	logic [vrle_pkg::LEN_W-1:0]    len_q;

	logic [1:0]                    phase_eff;
	logic [vrle_pkg::COUNT_W-1:0]  count_eff;
	logic                          done;
	logic                          is_escape;
	logic                          start_run;
	logic [SPAN_W-1:0]             space;
	logic [vrle_pkg::LEN_W-1:0]    seg;
	logic [SPAN_W-1:0]             row_sum;
	logic                          wrap;
	logic [PROD_W-1:0]             addr_full;
	logic [vrle_pkg::COUNT_W-1:0]  count_next;

	assign phase_eff = in_restart ? PH_NORMAL : phase_q;
	assign count_eff = in_restart ? '0 : count_q;
	assign done      = count_eff >= vrle_pkg::COUNT_W'(total_q);
	assign is_escape = (in_byte == vrle_pkg::ESCAPE_BYTE);

	always_comb begin
		case (phase_eff)
			PH_VALUE: start_run = 1'b0;
			PH_COUNT: start_run = !done && (in_byte != '0);
			default:  start_run = !done && !is_escape;
		endcase
	end

	assign sts.start_run = start_run;
	assign space        = ROWS_EXT - SPAN_W'(row_q);
	assign sts.seg_last = SPAN_W'(len_q) <= space;
	assign seg          = sts.seg_last ? len_q : space[vrle_pkg::LEN_W-1:0];
	assign row_sum      = SPAN_W'(row_q) + SPAN_W'(seg);
	assign wrap         = row_sum >= ROWS_EXT;
	assign addr_full    = PROD_W'(row_q) * PROD_W'(BYTES_PER_ROW) + PROD_W'(col_q);
	assign count_next   = count_q + vrle_pkg::COUNT_W'(seg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NORMAL;
			run_value_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
			count_q     <= '0;
			total_q     <= vrle_pkg::TOTAL_RESET;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_total;
			end
			if (cmd.load) begin
				if (in_restart) begin
					row_q   <= '0;
					col_q   <= '0;
					phase_q <= PH_NORMAL;
					count_q <= '0;
				end
				if (!done) begin
					case (phase_eff)
						PH_VALUE: begin
							run_value_q <= in_byte;
							phase_q     <= PH_COUNT;
						end
						PH_COUNT: begin
							phase_q <= PH_NORMAL;
						end
						default: begin
							phase_q <= is_escape ? PH_VALUE : PH_NORMAL;
						end
					endcase
				end
			end
			if (cmd.step) begin
				count_q <= count_next;
				if (wrap) begin
					row_q <= '0;
					col_q <= (col_q == COL_LAST) ? '0 : col_q + 1'b1;
				end else begin
					row_q <= row_sum[ROW_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (phase_eff == PH_COUNT) begin
				seg_value_q <= run_value_q;
				len_q       <= in_byte;
			end else begin
				seg_value_q <= in_byte;
				len_q       <= vrle_pkg::LEN_W'(1);
			end
		end
		if (cmd.step) begin
			len_q         <= len_q - seg;
			fill_value    <= seg_value_q;
			start_address <= addr_full[vrle_pkg::ADDR_W-1:0];
			seg_length    <= seg;
			last_segment  <= sts.seg_last;
			all_done      <= count_next >= vrle_pkg::COUNT_W'(total_q);
		end
	end

endmodule

// ===== rtl/vertical_rle_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_rle_decoder
// escape-byte run-length decoder emitting vertical fill segments
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// s        in         s_tvalid / s_tready  tdata: data_byte, tuser: restart
// m        out        m_tvalid / m_tready  tdata: value/addr/length, tlast, tuser
// cfg      in         cfg_valid/cfg_ready  output_total
//
// a literal byte yields one segment, escape and value bytes none, a run byte
// n segments (at most 4 with the default 100 rows), one segment per datapath step
// reset clears position, parse phase and count; output_total resets to 2000
// an input byte is taken while the previous last segment waits in the
// output register; segment steps stall while that register is held
// ----------------------------------------------------------------------------
module vertical_rle_decoder #(
	parameter int BYTES_PER_ROW = vrle_pkg::DEF_BYTES_PER_ROW,
	parameter int ROWS          = vrle_pkg::DEF_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [vrle_pkg::DATA_W-1:0]     s_tdata,  // data_byte
	input  logic                            s_tuser,  // restart
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [vrle_pkg::M_TDATA_W-1:0]  m_tdata,  // fill_value, start_address, seg_length
	output logic                            m_tlast,
	output logic                            m_tuser,  // all_done
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vrle_pkg::TOTAL_W-1:0]    cfg_data
);

	localparam int PAD_W = vrle_pkg::M_TDATA_W - vrle_pkg::DATA_W - vrle_pkg::ADDR_W
		- vrle_pkg::LEN_W;

	vrle_pkg::ctrl_cmd_t  cmd;
	vrle_pkg::dp_status_t sts;

	logic [vrle_pkg::DATA_W-1:0] fill_value;
	logic [vrle_pkg::ADDR_W-1:0] start_address;
	logic [vrle_pkg::LEN_W-1:0]  seg_length;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {{PAD_W{1'b0}}, seg_length, start_address, fill_value};

	vrle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vrle_dp #(
		.BYTES_PER_ROW (BYTES_PER_ROW),
		.ROWS          (ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_byte       (s_tdata),
		.in_restart    (s_tuser),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_total     (cfg_data),
		.fill_value    (fill_value),
		.start_address (start_address),
		.seg_length    (seg_length),
		.last_segment  (m_tlast),
		.all_done      (m_tuser)
	);

	a_load_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step in the same cycle");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> m_tvalid)
		else $error("segment step did not fill output register");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> $past(cmd.step && sts.seg_last))
		else $error("returned to idle before final segment");

endmodule

// ===== tb/vertical_rle_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_rle_decoder_tb
// self-checking bench for the escape-byte vertical run-length decoder
// ----------------------------------------------------------------------------
// bytes go in on the s channel and fill segments come out on the m channel.
// each accepted byte is decoded by an in-bench tracker of screen position,
// parse phase and produced count, which queues the segments it expects. every
// accepted segment is compared field by field against the oldest entry.
// output_total is rewritten between phases while the decoder is idle.
// directed bytes cover literals, escapes, zero counts and restarts. random
// bytes are mostly well-formed literals and runs, and both sides idle in random bursts.
// ----------------------------------------------------------------------------
module vertical_rle_decoder_tb;

	localparam int BYTES_PER_ROW = vrle_pkg::DEF_BYTES_PER_ROW;
	localparam int ROWS          = vrle_pkg::DEF_ROWS;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 120;

	typedef enum logic [1:0] {
		PH_NORMAL,
		PH_VALUE,
		PH_COUNT
	} parse_phase_t;

	typedef struct packed {
		logic [7:0]  value;
		logic [10:0] addr;
		logic [7:0]  len;
		logic        last;
		logic        done;
	} fill_seg_t;

	class column_filler;
		logic [13:0]  output_total;
		parse_phase_t phase;
		logic [7:0]   run_value;
		int unsigned  row;
		int unsigned  col;
		logic [14:0]  produced;
		fill_seg_t    pending_fills[$];
		int           errors;

		function new();
			output_total = vrle_pkg::TOTAL_RESET;
			phase        = PH_NORMAL;
			run_value    = '0;
			row          = 0;
			col          = 0;
			produced     = '0;
			errors       = 0;
		endfunction

		function void set_total(logic [13:0] v);
			output_total = v;
		endfunction

		function int pending();
			return pending_fills.size();
		endfunction

		function void fill_run(logic [7:0] v, int unsigned len);
			int unsigned room;
			int unsigned seg;
			fill_seg_t   s;
			while (len > 0) begin
				room = ROWS - row;
				seg = (len < room) ? len : room;
				produced = 15'(produced + seg);
				s.value = v;
				s.addr = 11'(row * BYTES_PER_ROW + col);
				s.len = 8'(seg);
				s.last = (len == seg);
				s.done = (produced >= output_total);
				pending_fills.push_back(s);
				row += seg;
				if (row >= ROWS) begin
					row = 0;
					col++;
					if (col >= BYTES_PER_ROW)
						col = 0;
				end
				len -= seg;
			end
		endfunction

		function void take_byte(logic [7:0] b, logic restart);
			if (restart) begin
				row = 0;
				col = 0;
				phase = PH_NORMAL;
				produced = '0;
			end
			if (produced >= output_total)
				return;
			case (phase)
				PH_VALUE: begin
					run_value = b;
					phase = PH_COUNT;
				end
				PH_COUNT: begin
					phase = PH_NORMAL;
					fill_run(run_value, b);
				end
				default: begin
					phase = PH_NORMAL;
					if (b == vrle_pkg::ESCAPE_BYTE)
						phase = PH_VALUE;
					else
						fill_run(b, 1);
				end
			endcase
		endfunction

		function void compare(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_fill(logic [31:0] tdata, logic tlast, logic tuser);
			fill_seg_t want;
			if (pending_fills.size() == 0) begin
				$display("%0t: unexpected segment, expected none actual tdata %h", $time, tdata);
				errors++;
				return;
			end
			want = pending_fills.pop_front();
			compare("fill_value", want.value, tdata[7:0]);
			compare("start_address", want.addr, tdata[18:8]);
			compare("seg_length", want.len, tdata[26:19]);
			compare("last_segment", want.last, tlast);
			compare("all_done", want.done, tuser);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // data_byte
	logic        s_tuser;   // restart
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // fill_value, start_address, seg_length
	logic        m_tlast;
	logic        m_tuser;   // all_done
	logic        cfg_valid;
	logic        cfg_ready;
	logic [13:0] cfg_data;

	bit quiet;
	bit hold_output;
	bit hold_taken;

	column_filler filler;

	vertical_rle_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("vertical_rle_decoder verification failed");
		$finish;
	end

	// output side: random stalls, plus one long hold on request
	initial begin
		m_tready = 1'b0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output && !hold_taken) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_taken = 1'b1;
				m_tready = 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			filler.match_fill(m_tdata, m_tlast, m_tuser);
	end

	task automatic push_byte(input logic [7:0] b, input logic restart, input bit no_gap = 0);
		s_tdata = b;
		s_tuser = restart;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		filler.take_byte(b, restart);
		@(negedge clk);
		if (!quiet && !no_gap && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
	endtask

	task automatic push_run(input logic [7:0] v, input logic [7:0] n, input logic restart);
		push_byte(vrle_pkg::ESCAPE_BYTE, restart);
		push_byte(v, 1'b0);
		push_byte(n, 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (filler.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_total(input logic [13:0] v);
		wait_drained();
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		filler.set_total(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_stream(input int count, input int restart_odds);
		int          sent;
		int unsigned pick;
		logic [7:0]  b;
		logic [7:0]  n;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				do b = 8'($urandom_range(0, 255)); while (b == vrle_pkg::ESCAPE_BYTE);
				push_byte(b, $urandom_range(1, restart_odds) == 1);
				sent += 1;
			end else if (pick < 88) begin
				case ($urandom_range(0, 3))
					0: n = 8'd255;
					1: n = 8'($urandom_range(0, 255));
					default: n = 8'($urandom_range(0, 12));
				endcase
				push_run(8'($urandom_range(0, 255)), n, $urandom_range(1, restart_odds) == 1);
				sent += 3;
			end else begin
				push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				sent += 1;
			end
		end
	endtask

	initial begin
		filler = new();
		quiet = 1'b0;
		hold_output = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed bytes at the reset total
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7E, 1'b0);
		push_run(vrle_pkg::ESCAPE_BYTE, 8'd3, 1'b0);
		push_run(8'h55, 8'd0, 1'b0);
		push_run(8'hAA, 8'd255, 1'b0);
		push_run(8'h3C, 8'd98, 1'b0);
		push_byte(vrle_pkg::ESCAPE_BYTE, 1'b0);
		push_byte(8'h12, 1'b1);
		push_byte(vrle_pkg::ESCAPE_BYTE, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(vrle_pkg::ESCAPE_BYTE, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h01, 1'b0);

		// largest total: long runs wrap past the last column
		write_total(14'h3FFF);
		push_byte(8'h5A, 1'b1);
		repeat (9) push_run(8'($urandom_range(0, 255)), 8'd255, 1'b0);
		random_stream(15, 25);

		// output held back while input keeps coming
		hold_output = 1'b1;
		repeat (20) push_byte(8'($urandom_range(0, 8'h90)), 1'b0, 1'b1);
		wait_drained();
		random_stream(15, 25);

		// zero total: every byte ignored
		write_total(14'd0);
		push_byte(8'h11, 1'b1);
		push_run(8'h22, 8'd5, 1'b1);
		push_byte(8'hFF, 1'b0);

		// small total: done reached often, restarts resume
		write_total(14'd40);
		random_stream(30, 8);

		write_total(14'($urandom_range(1, 3000)));
		random_stream(12, 10);
		write_total(14'($urandom_range(100, 16383)));
		quiet = 1'b1;
		random_stream(20, 10);

		wait_drained();
		if (filler.errors == 0) begin
			$display("vertical_rle_decoder verification clean");
		end else begin
			$display("vertical_rle_decoder verification failed");
		end
		$finish;
	end

endmodule
